FILE: sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Shared constants, codes, entry layout and arithmetic unit operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned MarginW = 16;
  localparam int unsigned HandleW = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TimeW-1:0]   SlicePeriodReset  = 64'd62500;
  localparam logic [MarginW-1:0] SafetyMarginReset = 16'd100;

  // Command codes
  localparam logic [CmdW-1:0] CMD_ADD     = 2'd0;
  localparam logic [CmdW-1:0] CMD_CHECK   = 2'd1;
  localparam logic [CmdW-1:0] CMD_SL_EN   = 2'd2;
  localparam logic [CmdW-1:0] CMD_SL_DIS  = 2'd3;

  // Result kinds
  localparam logic [KindW-1:0] KIND_USER  = 3'd0;
  localparam logic [KindW-1:0] KIND_SLICE = 3'd1;
  localparam logic [KindW-1:0] KIND_CDSET = 3'd2;
  localparam logic [KindW-1:0] KIND_STOP  = 3'd3;
  localparam logic [KindW-1:0] KIND_REJ   = 3'd4;
  localparam logic [KindW-1:0] KIND_DONE  = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SLICE_PERIOD  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAFETY_MARGIN = 1'd1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_GT
  } alu_op_e;

  typedef struct packed {
    logic [TimeW-1:0]   expire;
    logic [TimeW-1:0]   period;
    logic [HandleW-1:0] handle;
    logic               is_slice;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/stq_if.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue channels
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stq_in_if;
  logic                         valid;
  logic                         ready;
  logic [stq_pkg::CmdW-1:0]     cmd;
  logic [stq_pkg::TimeW-1:0]    now_count;
  logic [stq_pkg::TimeW-1:0]    countdown;
  logic [stq_pkg::TimeW-1:0]    period;
  logic [stq_pkg::HandleW-1:0]  handle;

  modport source (output valid, cmd, now_count, countdown, period, handle, input ready);
  modport sink (input valid, cmd, now_count, countdown, period, handle, output ready);
endinterface

interface stq_out_if;
  logic                         valid;
  logic                         ready;
  logic [stq_pkg::KindW-1:0]    kind;
  logic [stq_pkg::HandleW-1:0]  fired_handle;
  logic [stq_pkg::TimeW-1:0]    timer_countdown;
  logic                         last;

  modport source (output valid, kind, fired_handle, timer_countdown, last, input ready);
  modport sink (input valid, kind, fired_handle, timer_countdown, last, output ready);
endinterface

`default_nettype wire

FILE: sv/sorted_timer_event_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue core
// Keeps timer events sorted by expiry, fires due events, reports countdown.
// ----------------------------------------------------------------------------
// Operation: add/enable walk the store from the tail, comparing and shifting one
//   entry at a time, then report; disable and each fired event walk the store,
//   plus a re-insert walk for periodic events. Output stalls lengthen these.
// Throughput: one transaction at a time; the next is taken once the last result
//   of the current one is registered.
// Reset: queue empty, time slice inactive, registers at reset values.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_event_queue_core #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QueueDepthDefault
) (
  input  var logic                         clk_i,
  input  var logic                         rst_ni,
  stq_in_if.sink                           in_if,
  stq_out_if.source                        out_if,
  input  var logic                         cfg_we_i,
  input  var logic [stq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  var logic [stq_pkg::TimeW-1:0]    cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_INS_RD, ST_INS_CMP, ST_CHK_RD, ST_CHK_CMP, ST_CHK_EMIT,
    ST_REM_RD, ST_REM_CHK, ST_REP, ST_REP_A, ST_REP_B, ST_REP_C, ST_EMIT_LAST
  } state_e;

  state_e                         state_q;
  logic [stq_pkg::TimeW-1:0]      slice_period_q;
  logic [stq_pkg::MarginW-1:0]    margin_q;
  logic [CntW-1:0]                count_q;
  logic                           slice_active_q;
  logic [CntW-1:0]                pos_q;
  logic [CntW-1:0]                idx_q;
  logic [CntW-1:0]                fired_q;
  logic                           found_q;
  logic                           flag_q;
  logic [stq_pkg::CmdW-1:0]       cmd_q;
  logic [stq_pkg::TimeW-1:0]      now_q;
  logic [stq_pkg::TimeW-1:0]      addend_q;
  logic [stq_pkg::TimeW-1:0]      acc_q;
  logic [stq_pkg::TimeW-1:0]      cd_q;
  logic [stq_pkg::KindW-1:0]      kind_q;
  stq_pkg::entry_t                ins_q;

  logic                           out_valid_q;
  logic [stq_pkg::KindW-1:0]      out_kind_q;
  logic [stq_pkg::HandleW-1:0]    out_handle_q;
  logic [stq_pkg::TimeW-1:0]      out_cd_q;
  logic                           out_last_q;

  stq_pkg::alu_op_e               alu_op;
  logic [stq_pkg::TimeW-1:0]      alu_a;
  logic [stq_pkg::TimeW-1:0]      alu_b;
  logic [stq_pkg::TimeW-1:0]      alu_res;
  logic                           alu_gt;

  logic                           mem_we;
  logic [AddrW-1:0]               mem_waddr;
  stq_pkg::entry_t                mem_wdata;
  logic [AddrW-1:0]               mem_raddr;
  stq_pkg::entry_t                mem_rdata;

  logic                           slot_free;
  logic                           emit_now;
  logic [stq_pkg::TimeW-1:0]      eff_period;
  logic [CntW-1:0]                pos_m1;
  logic [CntW-1:0]                idx_m1;

  assign slot_free  = !out_valid_q || out_if.ready;
  assign emit_now   = slot_free && (state_q == ST_CHK_EMIT || state_q == ST_EMIT_LAST);
  assign eff_period = (slice_period_q == '0) ? {{(stq_pkg::TimeW-1){1'b0}}, 1'b1}
                                             : slice_period_q;
  assign pos_m1     = pos_q - OneCnt;
  assign idx_m1     = idx_q - OneCnt;

  assign in_if.ready            = (state_q == ST_IDLE);
  assign out_if.valid           = out_valid_q;
  assign out_if.kind            = out_kind_q;
  assign out_if.fired_handle    = out_handle_q;
  assign out_if.timer_countdown = out_cd_q;
  assign out_if.last            = out_last_q;

  stq_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .gt_o  (alu_gt)
  );

  stq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Steer the shared arithmetic unit
  always_comb begin
    alu_op = stq_pkg::ALU_ADD;
    alu_a  = now_q;
    alu_b  = addend_q;
    case (state_q)
      ST_INS_CMP: begin
        alu_op = stq_pkg::ALU_GT;
        alu_a  = mem_rdata.expire;
        alu_b  = ins_q.expire;
      end
      ST_CHK_CMP: begin
        alu_op = stq_pkg::ALU_GT;
        alu_a  = mem_rdata.expire;
        alu_b  = now_q;
      end
      ST_REP_A: begin
        alu_b  = {{(stq_pkg::TimeW-stq_pkg::MarginW){1'b0}}, margin_q};
      end
      ST_REP_B: begin
        alu_op = stq_pkg::ALU_GT;
        alu_a  = mem_rdata.expire;
        alu_b  = acc_q;
      end
      ST_REP_C: begin
        alu_op = stq_pkg::ALU_SUB;
        alu_a  = mem_rdata.expire;
        alu_b  = now_q;
      end
      default: ;
    endcase
  end

  // Drive the store ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q[AddrW-1:0];
    mem_wdata = ins_q;
    mem_raddr = '0;
    case (state_q)
      ST_INS_RD: begin
        mem_raddr = pos_m1[AddrW-1:0];
        mem_we    = (pos_q == '0);
      end
      ST_INS_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = alu_gt ? mem_rdata : ins_q;
      end
      ST_REM_RD: begin
        mem_raddr = idx_q[AddrW-1:0];
      end
      ST_REM_CHK: begin
        mem_we    = found_q;
        mem_waddr = idx_m1[AddrW-1:0];
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      slice_period_q <= stq_pkg::SlicePeriodReset;
      margin_q       <= stq_pkg::SafetyMarginReset;
      count_q        <= '0;
      slice_active_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          stq_pkg::CFG_SLICE_PERIOD:  slice_period_q <= cfg_wdata_i;
          stq_pkg::CFG_SAFETY_MARGIN: margin_q <= cfg_wdata_i[stq_pkg::MarginW-1:0];
          default: ;
        endcase
      end
      if (out_if.ready && !emit_now) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            cmd_q    <= in_if.cmd;
            now_q    <= in_if.now_count;
            pos_q    <= count_q;
            cd_q     <= '0;
            fired_q  <= '0;
            case (in_if.cmd)
              stq_pkg::CMD_ADD: begin
                addend_q        <= in_if.countdown;
                ins_q.period    <= in_if.period;
                ins_q.handle    <= in_if.handle;
                ins_q.is_slice  <= 1'b0;
                if (in_if.countdown == '0 || count_q == DepthCnt) begin
                  kind_q  <= stq_pkg::KIND_REJ;
                  state_q <= ST_EMIT_LAST;
                end else begin
                  state_q <= ST_SUM;
                end
              end
              stq_pkg::CMD_CHECK: begin
                state_q <= ST_CHK_RD;
              end
              stq_pkg::CMD_SL_EN: begin
                addend_q        <= eff_period;
                ins_q.period    <= eff_period;
                ins_q.handle    <= '0;
                ins_q.is_slice  <= 1'b1;
                if (slice_active_q) begin
                  kind_q  <= stq_pkg::KIND_DONE;
                  state_q <= ST_EMIT_LAST;
                end else if (count_q == DepthCnt) begin
                  kind_q  <= stq_pkg::KIND_REJ;
                  state_q <= ST_EMIT_LAST;
                end else begin
                  slice_active_q <= 1'b1;
                  state_q        <= ST_SUM;
                end
              end
              default: begin
                if (!slice_active_q) begin
                  kind_q  <= stq_pkg::KIND_DONE;
                  state_q <= ST_EMIT_LAST;
                end else begin
                  slice_active_q <= 1'b0;
                  idx_q          <= '0;
                  found_q        <= 1'b0;
                  state_q        <= ST_REM_RD;
                end
              end
            endcase
          end
        end

        ST_SUM: begin
          ins_q.expire <= alu_res;
          state_q      <= ST_INS_RD;
        end

        // Walk down from the tail, shifting later expiries up one slot
        ST_INS_RD: begin
          if (pos_q == '0) begin
            count_q <= count_q + OneCnt;
            if (cmd_q == stq_pkg::CMD_CHECK) begin
              state_q <= ST_CHK_RD;
            end else begin
              state_q <= ST_REP;
            end
          end else begin
            state_q <= ST_INS_CMP;
          end
        end

        ST_INS_CMP: begin
          if (alu_gt) begin
            pos_q   <= pos_m1;
            state_q <= ST_INS_RD;
          end else begin
            count_q <= count_q + OneCnt;
            if (cmd_q == stq_pkg::CMD_CHECK) begin
              state_q <= ST_CHK_RD;
            end else begin
              kind_q  <= stq_pkg::KIND_DONE;
              state_q <= ST_EMIT_LAST;
            end
          end
        end

        ST_CHK_RD: begin
          if (count_q == '0 || fired_q == DepthCnt) begin
            state_q <= ST_REP;
          end else begin
            state_q <= ST_CHK_CMP;
          end
        end

        // Fire the head when due
        ST_CHK_CMP: begin
          if (alu_gt) begin
            state_q <= ST_REP;
          end else begin
            ins_q.is_slice <= mem_rdata.is_slice;
            ins_q.handle   <= mem_rdata.is_slice ? '0 : mem_rdata.handle;
            ins_q.period   <= mem_rdata.is_slice ? eff_period : mem_rdata.period;
            addend_q       <= mem_rdata.is_slice ? eff_period : mem_rdata.period;
            state_q        <= ST_CHK_EMIT;
          end
        end

        ST_CHK_EMIT: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= ins_q.is_slice ? stq_pkg::KIND_SLICE : stq_pkg::KIND_USER;
            out_handle_q <= ins_q.handle;
            out_cd_q     <= '0;
            out_last_q   <= 1'b0;
            fired_q      <= fired_q + OneCnt;
            idx_q        <= OneCnt;
            found_q      <= 1'b1;
            state_q      <= ST_REM_RD;
          end
        end

        // Remove one entry by shifting the rest toward the head
        ST_REM_RD: begin
          if (idx_q == count_q) begin
            if (found_q) begin
              count_q <= count_q - OneCnt;
            end
            if (cmd_q == stq_pkg::CMD_CHECK) begin
              pos_q <= count_q - OneCnt;
              if (addend_q != '0) begin
                state_q <= ST_SUM;
              end else begin
                state_q <= ST_CHK_RD;
              end
            end else begin
              state_q <= ST_REP;
            end
          end else begin
            state_q <= ST_REM_CHK;
          end
        end

        ST_REM_CHK: begin
          if (!found_q && mem_rdata.is_slice) begin
            found_q <= 1'b1;
          end
          idx_q   <= idx_q + OneCnt;
          state_q <= ST_REM_RD;
        end

        // Countdown for the head, never below the margin
        ST_REP: begin
          if (count_q == '0) begin
            kind_q  <= stq_pkg::KIND_STOP;
            state_q <= ST_EMIT_LAST;
          end else begin
            state_q <= ST_REP_A;
          end
        end

        ST_REP_A: begin
          acc_q   <= alu_res;
          state_q <= ST_REP_B;
        end

        ST_REP_B: begin
          flag_q  <= alu_gt;
          state_q <= ST_REP_C;
        end

        ST_REP_C: begin
          cd_q    <= flag_q ? alu_res
                            : {{(stq_pkg::TimeW-stq_pkg::MarginW){1'b0}}, margin_q};
          kind_q  <= stq_pkg::KIND_CDSET;
          state_q <= ST_EMIT_LAST;
        end

        ST_EMIT_LAST: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= kind_q;
            out_handle_q <= '0;
            out_cd_q     <= cd_q;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count exceeds queue depth");

  a_slice_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slice_active_q && state_q == ST_IDLE) |-> count_q != '0)
    else $error("time slice active with empty queue");

  a_fire_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK_CMP) |-> fired_q < DepthCnt)
    else $error("too many events fired in one check");
`endif

endmodule

`default_nettype wire

FILE: sv/stq_alu.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue arithmetic unit
// One shared 64-bit adder, subtractor and magnitude compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stq_alu (
  input  var stq_pkg::alu_op_e          op_i,
  input  var logic [stq_pkg::TimeW-1:0] a_i,
  input  var logic [stq_pkg::TimeW-1:0] b_i,
  output var logic [stq_pkg::TimeW-1:0] res_o,
  output var logic                      gt_o
);

  // Select the operation; sums wrap
  always_comb begin
    gt_o = 1'b0;
    case (op_i)
      stq_pkg::ALU_ADD: res_o = a_i + b_i;
      stq_pkg::ALU_SUB: res_o = a_i - b_i;
      stq_pkg::ALU_GT: begin
        res_o = '0;
        gt_o  = (a_i > b_i);
      end
      default: res_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/stq_mem.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stq_mem #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QueueDepthDefault,
  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH)
) (
  input  var logic                 clk_i,
  input  var logic                 we_i,
  input  var logic [AddrW-1:0]     waddr_i,
  input  var stq_pkg::entry_t      wdata_i,
  input  var logic [AddrW-1:0]     raddr_i,
  output var stq_pkg::entry_t      rdata_o
);

  stq_pkg::entry_t mem_q [QUEUE_DEPTH];

  // Write and read entries
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: tb/stq_checker.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue checker
// Watches command and result transactions, predicts the result stream of
// each accepted command and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stq_checker
  import stq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  stq_in_if                    in_if,
  stq_out_if                   out_if,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [TimeW-1:0]     cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   countdown;
    logic               last;
  } outcome_t;

  // Shadow copy of the block's queue and registers
  entry_t           timers[$];
  logic [TimeW-1:0] slice_per;
  logic [MarginW-1:0] margin;
  bit               slice_on;
  outcome_t         outcomes[$];
  int               fails;
  int               pending;

  assign fail_count_o  = fails;
  assign pending_o     = pending;

  function automatic logic [TimeW-1:0] slice_step();
    return (slice_per == '0) ? TimeW'(1) : slice_per;
  endfunction

  // Insert after every entry with equal or earlier expiry; -1 when full
  function automatic int queue_timer(entry_t e);
    int pos;
    if (timers.size() >= QUEUE_DEPTH) return -1;
    pos = timers.size();
    while (pos > 0 && timers[pos-1].expire > e.expire) pos--;
    timers.insert(pos, e);
    return pos;
  endfunction

  function automatic void push(logic [KindW-1:0] k, logic [HandleW-1:0] h,
                               logic [TimeW-1:0] c, logic l);
    outcome_t o;
    o.kind = k; o.handle = h; o.countdown = c; o.last = l;
    outcomes.push_back(o);
  endfunction

  function automatic void push_head(logic [TimeW-1:0] now);
    logic [TimeW-1:0] ex;
    if (timers.size() == 0) begin
      push(KIND_STOP, '0, '0, 1'b1);
    end else begin
      ex = timers[0].expire;
      push(KIND_CDSET, '0, (ex > now + TimeW'(margin)) ? ex - now : TimeW'(margin), 1'b1);
    end
  endfunction

  function automatic void predict(logic [CmdW-1:0] cmd, logic [TimeW-1:0] now,
                                  logic [TimeW-1:0] cd, logic [TimeW-1:0] per,
                                  logic [HandleW-1:0] hd);
    entry_t e;
    entry_t h;
    int pos;
    int n;
    logic [TimeW-1:0] p;
    case (cmd)
      CMD_ADD: begin
        if (cd == '0) begin
          push(KIND_REJ, '0, '0, 1'b1);
        end else begin
          e.expire = now + cd; e.period = per; e.handle = hd; e.is_slice = 1'b0;
          pos = queue_timer(e);
          if (pos < 0) push(KIND_REJ, '0, '0, 1'b1);
          else if (pos == 0) push_head(now);
          else push(KIND_DONE, '0, '0, 1'b1);
        end
      end
      CMD_CHECK: begin
        n = 0;
        while (timers.size() > 0 && n < QUEUE_DEPTH && timers[0].expire <= now) begin
          h = timers.pop_front();
          p = h.is_slice ? slice_step() : h.period;
          push(h.is_slice ? KIND_SLICE : KIND_USER, h.is_slice ? '0 : h.handle,
               '0, 1'b0);
          n++;
          if (p != '0) begin
            e.expire = now + p; e.period = p;
            e.handle = h.is_slice ? '0 : h.handle; e.is_slice = h.is_slice;
            void'(queue_timer(e));
          end
        end
        push_head(now);
      end
      CMD_SL_EN: begin
        if (slice_on) begin
          push(KIND_DONE, '0, '0, 1'b1);
        end else begin
          e.expire = now + slice_step(); e.period = slice_step();
          e.handle = '0; e.is_slice = 1'b1;
          pos = queue_timer(e);
          if (pos < 0) begin
            push(KIND_REJ, '0, '0, 1'b1);
          end else begin
            slice_on = 1'b1;
            if (pos == 0) push_head(now);
            else push(KIND_DONE, '0, '0, 1'b1);
          end
        end
      end
      default: begin
        if (!slice_on) begin
          push(KIND_DONE, '0, '0, 1'b1);
        end else begin
          foreach (timers[i]) begin
            if (timers[i].is_slice) begin
              timers.delete(i);
              break;
            end
          end
          slice_on = 1'b0;
          push_head(now);
        end
      end
    endcase
  endfunction

  // Track registers, predict on commands, compare on results
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      timers.delete();
      outcomes.delete();
      slice_per <= SlicePeriodReset;
      margin    <= SafetyMarginReset;
      slice_on  = 1'b0;
      fails     <= 0;
      pending   <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SLICE_PERIOD) slice_per <= cfg_wdata_i;
        else margin <= cfg_wdata_i[MarginW-1:0];
      end
      if (in_if.valid && in_if.ready)
        predict(in_if.cmd, in_if.now_count, in_if.countdown, in_if.period, in_if.handle);
      if (out_if.valid && out_if.ready) begin
        if (outcomes.size() == 0) begin
          $display("%0t: unexpected result kind=%0d handle=%0d cd=%0d last=%0b",
                   $time, out_if.kind, out_if.fired_handle, out_if.timer_countdown,
                   out_if.last);
          fails <= fails + 1;
        end else begin
          exp_o = outcomes.pop_front();
          if (exp_o.kind !== out_if.kind || exp_o.handle !== out_if.fired_handle ||
              exp_o.countdown !== out_if.timer_countdown || exp_o.last !== out_if.last) begin
            $display("%0t: mismatch expected kind=%0d handle=%0d cd=%0d last=%0b",
                     $time, exp_o.kind, exp_o.handle, exp_o.countdown, exp_o.last);
            $display("%0t:          actual   kind=%0d handle=%0d cd=%0d last=%0b",
                     $time, out_if.kind, out_if.fired_handle, out_if.timer_countdown,
                     out_if.last);
            fails <= fails + 1;
          end
        end
      end
      pending <= outcomes.size();
    end
  end

endmodule

FILE: tb/tb_sorted_timer_event_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted timer event queue testbench
// Drives directed and random commands through several register settings
// with bursty sending and a stalling receiver; a checker gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_timer_event_queue_core;
  import stq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int          IdleLimit  = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [TimeW-1:0]   cfg_wdata_i;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  logic [TimeW-1:0] now_base;
  int   stall_mode = 0;

  stq_in_if  in_if();
  stq_out_if out_if();

  sorted_timer_event_queue_core #(.QUEUE_DEPTH(Depth)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_wdata_i(cfg_wdata_i)
  );

  stq_checker #(.QUEUE_DEPTH(Depth)) checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_wdata_i(cfg_wdata_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Receiver stalls on a changing pattern, with stall-free stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    if (!rst_ni) begin
      out_if.ready <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ($urandom_range(0, 1) != 0);
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one command and hold it until accepted
  task automatic send(logic [CmdW-1:0] cmd, logic [TimeW-1:0] now,
                      logic [TimeW-1:0] cd, logic [TimeW-1:0] per,
                      logic [HandleW-1:0] hd);
    in_if.valid     <= 1'b1;
    in_if.cmd       <= cmd;
    in_if.now_count <= now;
    in_if.countdown <= cd;
    in_if.period    <= per;
    in_if.handle    <= hd;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drain all results, then give the block time to settle before config
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * Depth + 40) @(posedge clk_i);
  endtask

  // Write one register; the caller drops the write enable afterwards
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  function automatic logic [TimeW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Small countdown mostly, so checks fire events
  function automatic logic [TimeW-1:0] rand_delta();
    case ($urandom_range(0, 9))
      0: return rand64();
      1: return '0;
      2: return TimeW'($urandom_range(1, 3));
      default: return TimeW'($urandom_range(1, 400));
    endcase
  endfunction

  // One random phase of well-formed traffic around an advancing clock
  task automatic random_phase(int items);
    int sent;
    int burst;
    logic [CmdW-1:0] cmd;
    logic [TimeW-1:0] per;
    int r;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < items; k++) begin
        r = $urandom_range(0, 19);
        if (r < 9) cmd = CMD_ADD;
        else if (r < 16) cmd = CMD_CHECK;
        else if (r < 18) cmd = CMD_SL_EN;
        else cmd = CMD_SL_DIS;
        if (cmd == CMD_CHECK) now_base = now_base + TimeW'($urandom_range(0, 300));
        per = ($urandom_range(0, 2) == 0) ? '0 : rand_delta();
        if ($urandom_range(0, 40) == 0) now_base = rand64();
        send(cmd, now_base, rand_delta(), per, HandleW'($urandom()));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 30));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_SLICE_PERIOD;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_ADD;
    in_if.now_count = '0;
    in_if.countdown = '0;
    in_if.period    = '0;
    in_if.handle    = '0;
    now_base     = 64'd1000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rejects, head insert, ties, extremes, slice enable/disable
    send(CMD_ADD, now_base, '0, '0, 8'h00);
    send(CMD_SL_DIS, now_base, '0, '0, 8'h00);
    send(CMD_CHECK, now_base, '0, '0, 8'h00);
    send(CMD_ADD, now_base, 64'd500, '0, 8'hFF);
    send(CMD_ADD, now_base, 64'd500, 64'd50, 8'h01);
    send(CMD_ADD, now_base, 64'd5, '0, 8'h02);
    send(CMD_ADD, now_base, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hAA);
    send(CMD_SL_EN, now_base, '0, '0, 8'h00);
    send(CMD_SL_EN, now_base, '0, '0, 8'h00);
    send(CMD_CHECK, now_base + 64'd10, '0, '0, 8'h00);
    send(CMD_CHECK, now_base + 64'd600, '0, '0, 8'h00);
    send(CMD_SL_DIS, now_base, '0, '0, 8'h00);
    send(CMD_SL_DIS, now_base, '0, '0, 8'h00);
    // Fill the queue, then overflow on add and on enable
    for (int i = 0; i < Depth + 1; i++)
      send(CMD_ADD, now_base, 64'd100000 + i, '0, HandleW'(i));
    send(CMD_SL_EN, now_base, '0, '0, 8'h00);
    // Wrapped re-arm that stays due hits the runaway bound
    send(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 8'h00);
    now_base = 64'hFFFF_FFFF_FFFF_FFFF;
    send(CMD_CHECK, now_base, '0, '0, 8'h00);
    settle();

    // Sweep register settings, extremes included, with random traffic
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SLICE_PERIOD, '0); write_reg(CFG_SAFETY_MARGIN, '0); end
        1: begin write_reg(CFG_SLICE_PERIOD, 64'd37); write_reg(CFG_SAFETY_MARGIN, 64'hFFFF); end
        2: begin write_reg(CFG_SLICE_PERIOD, '1); write_reg(CFG_SAFETY_MARGIN, 64'd1); end
        3: begin write_reg(CFG_SLICE_PERIOD, 64'd1); write_reg(CFG_SAFETY_MARGIN, 64'd100); end
        4: begin write_reg(CFG_SLICE_PERIOD, rand64());
                 write_reg(CFG_SAFETY_MARGIN, 64'($urandom_range(0, 65535))); end
        default: begin write_reg(CFG_SLICE_PERIOD, 64'd150); write_reg(CFG_SAFETY_MARGIN, 64'd20); end
      endcase
      cfg_we_i <= 1'b0;
      now_base = rand64();
      random_phase(48);
      // Advance the clock and disable the time slice before the next phase
      now_base = now_base + 64'd1000000;
      send(CMD_SL_DIS, now_base, '0, '0, 8'h00);
      settle();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (2 * Depth + 40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sorted_timer_event_queue_core.f
sv/stq_pkg.sv
sv/stq_if.sv
sv/stq_alu.sv
sv/stq_mem.sv
sv/sorted_timer_event_queue_core.sv
tb/stq_checker.sv
tb/tb_sorted_timer_event_queue_core.sv
